>>> rtl/cst_pkg.sv
// Shared types and constants for the character stream tokenizer.
// No dependencies; cst_front, cst_back and char_stream_tokenizer import this package.
package cst_pkg;

  // Fixed field widths of the token beat.
  localparam int KIND_BITS   = 5;
  localparam int POS_BITS    = 32;
  localparam int KW_BITS     = 3;
  localparam int QUEUE_DEPTH = 4;

  // Token kinds as they appear on the result channel.
  localparam logic [KIND_BITS-1:0] K_EOI     = 5'd0;
  localparam logic [KIND_BITS-1:0] K_SEMI    = 5'd1;
  localparam logic [KIND_BITS-1:0] K_PLUS    = 5'd2;
  localparam logic [KIND_BITS-1:0] K_MINUS   = 5'd3;
  localparam logic [KIND_BITS-1:0] K_TIMES   = 5'd4;
  localparam logic [KIND_BITS-1:0] K_DIV     = 5'd5;
  localparam logic [KIND_BITS-1:0] K_LP      = 5'd6;
  localparam logic [KIND_BITS-1:0] K_RP      = 5'd7;
  localparam logic [KIND_BITS-1:0] K_LCP     = 5'd8;
  localparam logic [KIND_BITS-1:0] K_RCP     = 5'd9;
  localparam logic [KIND_BITS-1:0] K_EQ      = 5'd10;
  localparam logic [KIND_BITS-1:0] K_LT      = 5'd11;
  localparam logic [KIND_BITS-1:0] K_GT      = 5'd12;
  localparam logic [KIND_BITS-1:0] K_IF      = 5'd13;
  localparam logic [KIND_BITS-1:0] K_WHILE   = 5'd14;
  localparam logic [KIND_BITS-1:0] K_IDENT   = 5'd15;
  localparam logic [KIND_BITS-1:0] K_NUM     = 5'd16;
  localparam logic [KIND_BITS-1:0] K_UNKNOWN = 5'd17;

  // Keyword prefix progress: i, if, w, wh, whi, whil, while.
  localparam logic [KW_BITS-1:0] KW_NONE  = 3'd0;
  localparam logic [KW_BITS-1:0] KW_I     = 3'd1;
  localparam logic [KW_BITS-1:0] KW_IF    = 3'd2;
  localparam logic [KW_BITS-1:0] KW_W     = 3'd3;
  localparam logic [KW_BITS-1:0] KW_WH    = 3'd4;
  localparam logic [KW_BITS-1:0] KW_WHI   = 3'd5;
  localparam logic [KW_BITS-1:0] KW_WHIL  = 3'd6;
  localparam logic [KW_BITS-1:0] KW_WHILE = 3'd7;

  // Scanner mode: nothing pending, a word pending or a number pending.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2
  } mode_t;

endpackage

>>> rtl/cst_queue.sv
// Small register FIFO between the scanner front and the token back end.
// Depends on nothing; DEPTH must be a power of two of at least two.
module cst_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  // Handshake on both sides.
  assign push_ready = (count_r != CNT_BITS'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/cst_front.sv
// Scanner front end: classifies each character, tracks the pending word or
// number and builds a record of up to two tokens per beat. Uses cst_pkg.
module cst_front import cst_pkg::*; #(
  parameter int VALUE_BITS  = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_char_code,
  input  logic in_end_of_text,
  output logic rec_valid,
  input  logic rec_ready,
  output logic [2*(KIND_BITS+POS_BITS+LENGTH_BITS+VALUE_BITS+1):0] rec_data
);

  localparam int TOK_W = KIND_BITS + POS_BITS + LENGTH_BITS + VALUE_BITS + 1;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LP     = 8'h28;
  localparam logic [7:0] CH_RP     = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_H   = 8'h68;
  localparam logic [7:0] CH_LO_I   = 8'h69;
  localparam logic [7:0] CH_LO_L   = 8'h6C;
  localparam logic [7:0] CH_LO_W   = 8'h77;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Kind of a one-character token.
  function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
    logic [KIND_BITS-1:0] k;
    begin
      case (c)
        CH_NUL:    k = K_EOI;
        CH_SEMI:   k = K_SEMI;
        CH_PLUS:   k = K_PLUS;
        CH_MINUS:  k = K_MINUS;
        CH_STAR:   k = K_TIMES;
        CH_SLASH:  k = K_DIV;
        CH_LP:     k = K_LP;
        CH_RP:     k = K_RP;
        CH_LBRACE: k = K_LCP;
        CH_RBRACE: k = K_RCP;
        CH_EQ:     k = K_EQ;
        CH_LT:     k = K_LT;
        CH_GT:     k = K_GT;
        default:   k = K_UNKNOWN;
      endcase
      return k;
    end
  endfunction

  // Next keyword prefix after one more word character.
  function automatic logic [KW_BITS-1:0] keyword_next(input logic [KW_BITS-1:0] m,
                                                      input logic [7:0] c);
    logic [KW_BITS-1:0] r;
    begin
      r = KW_NONE;
      case (m)
        KW_I:    if (c == CH_LO_F) r = KW_IF;
        KW_W:    if (c == CH_LO_H) r = KW_WH;
        KW_WH:   if (c == CH_LO_I) r = KW_WHI;
        KW_WHI:  if (c == CH_LO_L) r = KW_WHIL;
        KW_WHIL: if (c == CH_LO_E) r = KW_WHILE;
        default: r = KW_NONE;
      endcase
      return r;
    end
  endfunction

  // Saturating acc * 10 + d; the top bit of the result is the overflow flag.
  function automatic logic [VALUE_BITS:0] add_digit(input logic [VALUE_BITS-1:0] acc,
                                                    input logic [3:0] d);
    logic [VALUE_BITS+3:0] prod;
    begin
      prod = {3'b000, acc, 1'b0} + {1'b0, acc, 3'b000} + {{VALUE_BITS{1'b0}}, d};
      if (prod[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
        return {1'b1, {VALUE_BITS{1'b1}}};
      end
      return {1'b0, prod[VALUE_BITS-1:0]};
    end
  endfunction

  // Token for a pending word or number.
  function automatic logic [TOK_W-1:0] pend_tok(input mode_t m,
                                                input logic [KW_BITS-1:0] kw,
                                                input logic [POS_BITS-1:0] start,
                                                input logic [LENGTH_BITS-1:0] len,
                                                input logic [VALUE_BITS-1:0] acc,
                                                input logic ovf);
    logic [KIND_BITS-1:0]  kind;
    logic [VALUE_BITS-1:0] val;
    logic                  sat;
    begin
      val = '0;
      sat = 1'b0;
      if (m == MODE_NUM) begin
        kind = K_NUM;
        val  = acc;
        sat  = ovf;
      end else if (kw == KW_IF) begin
        kind = K_IF;
      end else if (kw == KW_WHILE) begin
        kind = K_WHILE;
      end else begin
        kind = K_IDENT;
      end
      return {kind, start, len, val, sat};
    end
  endfunction

  // Scanner state.
  mode_t                  mode_r, mode_nxt;
  logic [POS_BITS-1:0]    pos_r, pos_nxt;
  logic [POS_BITS-1:0]    start_r, start_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0]  acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [KW_BITS-1:0]     kw_r, kw_nxt;

  // State after the character but before an end-of-text flush.
  mode_t                  mid_mode;
  logic [POS_BITS-1:0]    mid_start;
  logic [LENGTH_BITS-1:0] mid_cnt;
  logic [VALUE_BITS-1:0]  mid_acc;
  logic                   mid_ovf;
  logic [KW_BITS-1:0]     mid_kw;

  logic                   is_letter, is_digit, is_space, cont;
  logic [3:0]             digit;
  logic [VALUE_BITS:0]    acc_step;
  logic                   flush_old, emit_single, flush_late;
  logic [TOK_W-1:0]       tok_old, tok_single, tok_late, tok0, tok1;
  logic                   two_tok, any_tok;
  logic                   accept;

  // Character classes.
  always_comb begin
    is_letter = ((in_char_code >= CH_LO_A) && (in_char_code <= CH_LO_Z)) ||
                ((in_char_code >= CH_UP_A) && (in_char_code <= CH_UP_Z));
    is_digit  = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
    is_space  = (in_char_code == CH_SPACE) ||
                ((in_char_code >= CH_TAB) && (in_char_code <= CH_CR));
    digit     = in_char_code[3:0];
    cont      = ((mode_r == MODE_WORD) && (is_letter || is_digit)) ||
                ((mode_r == MODE_NUM) && is_digit);
    acc_step  = add_digit(cont ? acc_r : '0, digit);
  end

  // Next-state: extend, start or drop the pending token, then flush on end of text.
  always_comb begin
    mid_mode  = MODE_IDLE;
    mid_start = start_r;
    mid_cnt   = '0;
    mid_acc   = '0;
    mid_ovf   = 1'b0;
    mid_kw    = KW_NONE;
    if (cont) begin
      mid_mode = mode_r;
      mid_cnt  = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
      if (mode_r == MODE_WORD) begin
        mid_kw = keyword_next(kw_r, in_char_code);
      end else begin
        mid_acc = acc_step[VALUE_BITS-1:0];
        mid_ovf = ovf_r | acc_step[VALUE_BITS];
      end
    end else if (is_letter) begin
      mid_mode  = MODE_WORD;
      mid_start = pos_r;
      mid_cnt   = LENGTH_BITS'(1);
      if (in_char_code == CH_LO_I) begin
        mid_kw = KW_I;
      end else if (in_char_code == CH_LO_W) begin
        mid_kw = KW_W;
      end
    end else if (is_digit) begin
      mid_mode  = MODE_NUM;
      mid_start = pos_r;
      mid_cnt   = LENGTH_BITS'(1);
      mid_acc   = acc_step[VALUE_BITS-1:0];
    end

    pos_nxt   = pos_r + 1'b1;
    start_nxt = mid_start;
    if (in_end_of_text) begin
      mode_nxt = MODE_IDLE;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      ovf_nxt  = 1'b0;
      kw_nxt   = KW_NONE;
    end else begin
      mode_nxt = mid_mode;
      cnt_nxt  = mid_cnt;
      acc_nxt  = mid_acc;
      ovf_nxt  = mid_ovf;
      kw_nxt   = mid_kw;
    end
  end

  // Outputs: the old pending token, a one-character token, the flushed new token.
  always_comb begin
    flush_old   = !cont && (mode_r != MODE_IDLE);
    emit_single = !cont && !is_space && !is_letter && !is_digit;
    flush_late  = in_end_of_text && (mid_mode != MODE_IDLE);
    tok_old     = pend_tok(mode_r, kw_r, start_r, cnt_r, acc_r, ovf_r);
    tok_single  = {single_kind(in_char_code), pos_r, LENGTH_BITS'(1),
                   {VALUE_BITS{1'b0}}, 1'b0};
    tok_late    = pend_tok(mid_mode, mid_kw, mid_start, mid_cnt, mid_acc, mid_ovf);
    two_tok     = flush_old && (emit_single || flush_late);
    any_tok     = flush_old || emit_single || flush_late;
    if (flush_old) begin
      tok0 = tok_old;
      tok1 = emit_single ? tok_single : tok_late;
    end else begin
      tok0 = emit_single ? tok_single : tok_late;
      tok1 = tok_late;
    end
  end

  assign in_ready  = rec_ready;
  assign accept    = in_valid && rec_ready;
  assign rec_valid = in_valid && any_tok;
  assign rec_data  = {two_tok, tok1, tok0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      cnt_r   <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      kw_r    <= KW_NONE;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      kw_r    <= kw_nxt;
    end
  end

endmodule

>>> rtl/cst_back.sv
// Token back end: takes one record of one or two tokens from the queue and
// sends its tokens out one beat at a time from a holding register. Uses cst_pkg.
module cst_back import cst_pkg::*; #(
  parameter int VALUE_BITS  = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic rec_valid,
  output logic rec_ready,
  input  logic [2*(KIND_BITS+POS_BITS+LENGTH_BITS+VALUE_BITS+1):0] rec_data,
  output logic out_valid,
  input  logic out_ready,
  output logic [KIND_BITS-1:0] out_token_kind,
  output logic [POS_BITS-1:0] out_start_offset,
  output logic [LENGTH_BITS-1:0] out_token_length,
  output logic [VALUE_BITS-1:0] out_number_value,
  output logic out_value_saturated,
  output logic out_last_of_run
);

  localparam int TOK_W = KIND_BITS + POS_BITS + LENGTH_BITS + VALUE_BITS + 1;
  localparam int REC_W = 2 * TOK_W + 1;

  logic [REC_W-1:0] cur_r;
  logic             cur_valid_r, cur_valid_nxt;
  logic             sel_r, sel_nxt;
  logic [TOK_W-1:0] tok;
  logic             last_tok;

  // Current token of the held record.
  assign tok      = sel_r ? cur_r[2*TOK_W-1:TOK_W] : cur_r[TOK_W-1:0];
  assign last_tok = sel_r || !cur_r[REC_W-1];

  assign out_valid           = cur_valid_r;
  assign out_token_kind      = tok[TOK_W-1 -: KIND_BITS];
  assign out_start_offset    = tok[TOK_W-KIND_BITS-1 -: POS_BITS];
  assign out_token_length    = tok[VALUE_BITS+LENGTH_BITS:VALUE_BITS+1];
  assign out_number_value    = tok[VALUE_BITS:1];
  assign out_value_saturated = tok[0];
  assign out_last_of_run     = last_tok;

  // A new record loads when the holding register is empty or its last beat leaves.
  assign rec_ready = !cur_valid_r || (out_ready && last_tok);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    sel_nxt       = sel_r;
    if (rec_ready) begin
      cur_valid_nxt = rec_valid;
      sel_nxt       = 1'b0;
    end else if (out_ready) begin
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  // Record payload needs no reset.
  always_ff @(posedge clk) begin
    if (rec_ready && rec_valid) begin
      cur_r <= rec_data;
    end
  end

endmodule

>>> rtl/char_stream_tokenizer.sv
// Character stream tokenizer: one character per beat in, one token per beat out.
// A completed token is held in the record queue and then in the back end's holding register.
// Throughput: one character per cycle while the queue has room; the four-record
// queue absorbs short bursts of two-token characters; a long run stalls the input.
// Reset (synchronous, rst_n low) clears scanner state, position, queue and output.
// Depends on cst_pkg, cst_front, cst_queue and cst_back.
module char_stream_tokenizer import cst_pkg::*; #(
  parameter int VALUE_BITS  = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_char_code,
  input  logic in_end_of_text,
  output logic out_valid,
  input  logic out_ready,
  output logic [KIND_BITS-1:0] out_token_kind,
  output logic [POS_BITS-1:0] out_start_offset,
  output logic [LENGTH_BITS-1:0] out_token_length,
  output logic [VALUE_BITS-1:0] out_number_value,
  output logic out_value_saturated,
  output logic out_last_of_run
);

  localparam int TOK_W = KIND_BITS + POS_BITS + LENGTH_BITS + VALUE_BITS + 1;
  localparam int REC_W = 2 * TOK_W + 1;

  logic             fq_valid, fq_ready;
  logic [REC_W-1:0] fq_data;
  logic             qb_valid, qb_ready;
  logic [REC_W-1:0] qb_data;

  // Scanner front end.
  cst_front #(
    .VALUE_BITS  (VALUE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .rec_valid      (fq_valid),
    .rec_ready      (fq_ready),
    .rec_data       (fq_data)
  );

  // Record queue between front and back.
  cst_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // Token back end.
  cst_back #(
    .VALUE_BITS  (VALUE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rec_valid           (qb_valid),
    .rec_ready           (qb_ready),
    .rec_data            (qb_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_token_kind      (out_token_kind),
    .out_start_offset    (out_start_offset),
    .out_token_length    (out_token_length),
    .out_number_value    (out_number_value),
    .out_value_saturated (out_value_saturated),
    .out_last_of_run     (out_last_of_run)
  );

  // A saturated number always carries the clamped all-ones value.
  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_saturated |->
      (out_token_kind == K_NUM) && (&out_number_value))
    else $error("saturated token is not a clamped number");

  // Only number tokens carry a value.
  a_value_only_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind != K_NUM) |->
      (out_number_value == '0) && !out_value_saturated)
    else $error("non-number token carries a value");

  // One-character tokens have length one.
  a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_token_kind < K_IF) || (out_token_kind == K_UNKNOWN)) |->
      (out_token_length == LENGTH_BITS'(1)))
    else $error("one-character token with wrong length");

  // The first of two tokens from one character is followed by its partner.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("second token of a pair is missing");

endmodule
